[design/polynomial_eval_newton_inverse_macros.svh]
// Assertion macros for the polynomial evaluator.
`ifndef POLYNOMIAL_EVAL_NEWTON_INVERSE_MACROS_SVH
`define POLYNOMIAL_EVAL_NEWTON_INVERSE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define PEN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PEN_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define PEN_ASSERT(label, prop, msg)
`define PEN_ASSERT_IMPL(label, ante, cons, msg)
`endif
`endif

[design/pen_pkg.sv]
package pen_pkg;
    localparam int NCOEF = 6;
    localparam int DEG = 5;
    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        ACT_EVAL  = 2'd0,
        ACT_SLOPE = 2'd1,
        ACT_INV   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_TOL  = 3'd6,
        REG_ITER = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] operand;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               saturated;
        logic               zero_slope;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_item_t;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_LEAD,   // acc = coef[DEG] (or DEG*coef[DEG] in slope mode)
        OP_MUL,         // prod = acc * x, rounded and clamped
        OP_ADD,         // acc = prod + coefficient term k
        OP_SAVE_F,      // f = acc - y
        OP_SAVE_DF,     // df = acc
        OP_DIV_START,
        OP_DIV_STEP,
        OP_DIV_END,     // offset = clamp(quotient)
        OP_UPDATE       // x = x - offset
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       slope;
        logic [2:0] k;
        logic       use_x;    // multiply by Newton x instead of operand
        logic       clr;      // clear the saturation flag and x at item start
    } dp_cmd_t;

    typedef struct packed {
        logic df_zero;
        logic tol_hit;
        logic div_done;
    } dp_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [66:0] v,
                                                  inout logic flag);
        logic signed [31:0] r;
        if (v > 67'sd2147483647) begin
            flag = 1'b1;
            r = Q_MAX;
        end else if (v < -67'sd2147483648) begin
            flag = 1'b1;
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction
endpackage

[design/pen_datapath.sv]
module pen_datapath
    import pen_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    input  logic signed [31:0]  operand,
    input  logic signed [31:0]  coef [NCOEF],
    input  logic [30:0]         tolerance,
    output dp_stat_t            stat,
    output logic signed [31:0]  acc,
    output logic signed [31:0]  x,
    output logic                sat
);
    logic signed [31:0] acc_reg, acc_next, x_reg, x_next, prod_reg, prod_next;
    logic signed [31:0] f_reg, f_next, df_reg, df_next, off_reg, off_next;
    logic sat_reg, sat_next;
    // Restoring divider on magnitudes: 48-bit dividend, 32-bit divisor.
    logic [47:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic signed [31:0] mul_b, term;
    logic signed [63:0] mprod;
    logic signed [66:0] wide;
    logic [32:0] rem_sh, rem_sub;
    logic [48:0] qmag;
    logic [31:0] off_mag;
    logic f_flag;

    assign mul_b = cmd.use_x ? x_reg : operand;
    assign mprod = acc_reg * mul_b;
    assign rem_sh = {rem_reg[31:0], quo_reg[47]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign off_mag = off_reg[31] ? 32'(-off_reg) : off_reg;

    always_comb
    begin
        acc_next = acc_reg;
        x_next = x_reg;
        prod_next = prod_reg;
        f_next = f_reg;
        df_next = df_reg;
        off_next = off_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        neg_next = neg_reg;
        cnt_next = cnt_reg;
        f_flag = sat_reg;
        term = '0;
        wide = '0;
        qmag = '0;
        if (cmd.clr) begin
            f_flag = 1'b0;
            x_next = '0;
        end
        unique case (cmd.op)
            OP_NOP: ;
            OP_LOAD_LEAD:
            begin
                if (cmd.slope)
                    acc_next = sat32(67'(coef[DEG]) * 67'(DEG), f_flag);
                else
                    acc_next = coef[DEG];
            end
            OP_MUL:
            begin
                wide = (67'(mprod) + 67'sd32768) >>> 16;
                prod_next = sat32(wide, f_flag);
            end
            OP_ADD:
            begin
                if (cmd.slope)
                    term = sat32(67'(coef[cmd.k]) * 67'($signed({1'b0, cmd.k})), f_flag);
                else
                    term = coef[cmd.k];
                acc_next = sat32(67'(prod_reg) + 67'(term), f_flag);
            end
            OP_SAVE_F: f_next = sat32(67'(acc_reg) - 67'(operand), f_flag);
            OP_SAVE_DF: df_next = acc_reg;
            OP_DIV_START:
            begin
                quo_next = {(f_reg[31] ? 32'(-f_reg) : f_reg), 16'h0};
                dvs_next = df_reg[31] ? 32'(-df_reg) : df_reg;
                neg_next = f_reg[31] ^ df_reg[31];
                rem_next = '0;
                cnt_next = 6'd48;
            end
            OP_DIV_STEP:
            begin
                if (!rem_sub[32]) begin
                    rem_next = rem_sub;
                    quo_next = {quo_reg[46:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[46:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
            end
            OP_DIV_END:
            begin
                qmag = {1'b0, quo_reg};
                wide = neg_reg ? -67'(qmag) : 67'(qmag);
                off_next = sat32(wide, f_flag);
            end
            OP_UPDATE: x_next = sat32(67'(x_reg) - 67'(off_reg), f_flag);
            default: ;
        endcase
        sat_next = f_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            sat_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            sat_reg <= sat_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg <= x_next;
        prod_reg <= prod_next;
        f_reg <= f_next;
        df_reg <= df_next;
        off_reg <= off_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign stat.df_zero = (df_reg == '0);
    assign stat.tol_hit = ({1'b0, off_mag} < {2'b0, tolerance});
    assign stat.div_done = (cnt_reg == 6'd1);
    assign acc = acc_reg;
    assign x = x_reg;
    assign sat = sat_reg;
endmodule

[design/pen_ctrl.sv]
`include "polynomial_eval_newton_inverse_macros.svh"
module pen_ctrl
    import pen_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  max_iterations,
    output logic        out_load,
    output logic        out_res_sel_x,
    output logic        out_zero,
    output logic        zs,
    input  logic        out_free,
    output dp_cmd_t     cmd,
    input  dp_stat_t    stat
);
    typedef enum logic [3:0] {
        S_IDLE, S_LEAD, S_MUL, S_ADD, S_POST, S_DIV0, S_DIV, S_DIVE,
        S_TEST, S_UPD, S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] act_reg, act_next;
    logic       slope_reg, slope_next;
    logic [2:0] k_reg, k_next;
    logic [7:0] it_reg, it_next;
    logic       zs_reg, zs_next;

    always_comb
    begin
        state_next = state_reg;
        act_next = act_reg;
        slope_next = slope_reg;
        k_next = k_reg;
        it_next = it_reg;
        zs_next = zs_reg;
        cmd = '{op: OP_NOP, slope: slope_reg, k: k_reg, use_x: (act_reg == ACT_INV),
                clr: 1'b0};
        in_ready = (state_reg == S_IDLE);
        out_load = 1'b0;
        unique case (state_reg)
            S_IDLE:
            if (in_valid) begin
                cmd.clr = 1'b1;
                act_next = action;
                zs_next = 1'b0;
                it_next = '0;
                slope_next = (action == ACT_SLOPE);
                priority if (action == ACT_EVAL || action == ACT_SLOPE)
                    state_next = S_LEAD;
                else if (action == ACT_INV && max_iterations != '0)
                    state_next = S_LEAD;
                else
                    state_next = S_DONE;
            end
            S_LEAD:
            begin
                cmd.op = OP_LOAD_LEAD;
                k_next = 3'(DEG - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.op = OP_MUL;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.op = OP_ADD;
                k_next = k_reg - 3'd1;
                if (k_reg == (slope_reg ? 3'd1 : 3'd0))
                    state_next = (act_reg == ACT_INV) ? S_POST : S_DONE;
                else
                    state_next = S_MUL;
            end
            S_POST:
            begin
                if (!slope_reg) begin
                    cmd.op = OP_SAVE_F;
                    slope_next = 1'b1;
                    state_next = S_LEAD;
                end else begin
                    cmd.op = OP_SAVE_DF;
                    state_next = S_DIV0;
                end
            end
            S_DIV0:
            if (stat.df_zero) begin
                zs_next = 1'b1;
                state_next = S_DONE;
            end else begin
                cmd.op = OP_DIV_START;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (stat.div_done)
                    state_next = S_DIVE;
            end
            S_DIVE:
            begin
                cmd.op = OP_DIV_END;
                state_next = S_TEST;
            end
            S_TEST: state_next = stat.tol_hit ? S_DONE : S_UPD;
            S_UPD:
            begin
                cmd.op = OP_UPDATE;
                it_next = it_reg + 8'd1;
                slope_next = 1'b0;
                state_next = (it_reg + 8'd1 == max_iterations) ? S_DONE : S_LEAD;
            end
            S_DONE:
            if (out_free) begin
                out_load = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            act_reg <= '0;
            slope_reg <= 1'b0;
            k_reg <= '0;
            it_reg <= '0;
            zs_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            act_reg <= act_next;
            slope_reg <= slope_next;
            k_reg <= k_next;
            it_reg <= it_next;
            zs_reg <= zs_next;
        end
    end

    assign out_res_sel_x = (act_reg == ACT_INV);
    assign out_zero = (act_reg == ACT_NONE);
    assign zs = zs_reg;

    `PEN_ASSERT_IMPL(a_zs_inv, zs_reg, act_reg == ACT_INV, "zero slope outside inverse")
    `PEN_ASSERT_IMPL(a_load_done, out_load, state_reg == S_DONE, "result load outside done")
    `PEN_ASSERT_IMPL(a_iter_bound, state_reg == S_UPD, it_reg < max_iterations,
                     "iteration count past limit")
endmodule

[design/polynomial_eval_newton_inverse.sv]
// Evaluate and derivative each run one Horner pass; an undefined action goes
// straight to the result load. Inverse runs Newton steps (two Horner passes
// plus a radix-2 divider), up to max_iterations steps, then loads the result.
// One item at a time; the next item is taken while the result waits in the
// output register. Reset is asynchronous active low and restores register defaults.
`include "polynomial_eval_newton_inverse_macros.svh"
module polynomial_eval_newton_inverse
    import pen_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  cfg_item_t cfg_data
);
    logic signed [31:0] coef_reg [NCOEF];
    logic [30:0] tol_reg;
    logic [7:0]  iter_reg;
    in_item_t    item_reg;
    out_item_t   out_reg;
    logic        out_valid_reg;
    logic        accept, out_load, sel_x, zero_res, zs, out_free;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic signed [31:0] acc, x;
    logic        sat;

    assign cfg_ready = 1'b1;
    assign accept = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < NCOEF; i++)
                coef_reg[i] <= (i == 1) ? 32'sd65536 : 32'sd0;
            tol_reg <= 31'd66;
            iter_reg <= 8'd32;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_data.index == REG_TOL)
                    tol_reg <= cfg_data.data[30:0];
                else if (cfg_data.index == REG_ITER)
                    iter_reg <= cfg_data.data[7:0];
                else
                    coef_reg[cfg_data.index] <= cfg_data.data;
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        if (out_load) begin
            out_reg.result <= zero_res ? 32'sd0 : (sel_x ? x : acc);
            out_reg.saturated <= zero_res ? 1'b0 : sat;
            out_reg.zero_slope <= zs;
        end
    end

    pen_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready,
        .action(in_data.action), .max_iterations(iter_reg),
        .out_load, .out_res_sel_x(sel_x), .out_zero(zero_res), .zs, .out_free,
        .cmd, .stat
    );

    pen_datapath u_dp (
        .clk, .rst_n, .cmd, .operand(item_reg.operand), .coef(coef_reg),
        .tolerance(tol_reg), .stat, .acc, .x, .sat
    );

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    `PEN_ASSERT_IMPL(a_out_hold, out_valid && !out_ready, ##1 out_valid, "result dropped")
    `PEN_ASSERT_IMPL(a_no_overwrite, out_valid && !out_ready, !out_load,
                     "result overwritten")
    `PEN_ASSERT_IMPL(a_load_valid, out_load, ##1 out_valid, "loaded result not presented")
endmodule
